### design/rotation_matrix_to_quaternion_top_assert.svh
// Assertion macros used by the checker file rmq_checker.sv.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define RMQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rmq_pkg.sv
package rmq_pkg;

  localparam int ValW        = 16;
  localparam int FracBits    = 14;
  localparam int RadW        = ValW + 3;
  localparam int MagW        = ValW + 1;
  localparam int SqInW       = ((RadW - 1 + FracBits + 1) / 2) * 2;
  localparam int RootW       = SqInW / 2;
  localparam int RemW        = RootW + 3;
  localparam int DivW        = RootW + 1;
  localparam int NumW        = MagW + FracBits + 1;
  localparam int SqPerStage  = 2;
  localparam int SqStages    = RootW / SqPerStage;
  localparam int DivPerStage = 4;
  localparam int DivStages   = NumW / DivPerStage;
  localparam int CoreStages  = SqStages + 1 + DivStages;

  typedef enum logic [1:0] {
    SlotW,
    SlotX,
    SlotY,
    SlotZ
  } slot_e;

  typedef struct packed {
    logic                      degen;
    slot_e                     dom;
    logic [3:0]                neg;
    logic [3:0][MagW-1:0]      mag;
    logic [SqInW-1:0]          sq_v;
    logic [RemW-1:0]           sq_rem;
    logic [RootW-1:0]          root;
    logic [3:0][DivW:0]        dv_rem;
    logic [3:0][NumW-1:0]      dv_num;
  } pipe_t;

endpackage

### design/rmq_core.sv
module rmq_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  rmq_pkg::pipe_t pipe_i,
  output logic          valid_o,
  input  logic          stall_i,
  output rmq_pkg::pipe_t pipe_o
);
  import rmq_pkg::*;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic pipe_t sq_iter(pipe_t p);
    pipe_t r;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] tsub;
    r     = p;
    trial = {p.sq_rem[RemW-3:0], p.sq_v[SqInW-1 -: 2]};
    tsub  = RemW'({p.root, 2'b01});
    if (trial >= tsub) begin
      r.sq_rem = trial - tsub;
      r.root   = {p.root[RootW-2:0], 1'b1};
    end else begin
      r.sq_rem = trial;
      r.root   = {p.root[RootW-2:0], 1'b0};
    end
    r.sq_v = {p.sq_v[SqInW-3:0], 2'b00};
    return r;
  endfunction

  // Numerator is |d| scaled up plus s, so the quotient rounds to nearest.
  function automatic pipe_t div_setup(pipe_t p);
    pipe_t r;
    r = p;
    for (int l = 0; l < 4; l++) begin
      r.dv_rem[l] = '0;
      r.dv_num[l] = (NumW'(p.mag[l]) << FracBits) + NumW'(p.root);
    end
    return r;
  endfunction

  // One restoring division step per lane; quotient bits shift into dv_num.
  function automatic pipe_t div_iter(pipe_t p);
    pipe_t r;
    logic [DivW:0] sh;
    logic [DivW:0] den;
    r   = p;
    den = (DivW+1)'({p.root, 1'b0});
    for (int l = 0; l < 4; l++) begin
      sh = {p.dv_rem[l][DivW-1:0], p.dv_num[l][NumW-1]};
      if (sh >= den) begin
        r.dv_rem[l] = sh - den;
        r.dv_num[l] = {p.dv_num[l][NumW-2:0], 1'b1};
      end else begin
        r.dv_rem[l] = sh;
        r.dv_num[l] = {p.dv_num[l][NumW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  pipe_t                 st_q [CoreStages];
  logic                  v_q  [CoreStages];
  logic [CoreStages-1:0] go;

  // A stage loads when empty or when the one after it moves.
  always_comb begin
    go[CoreStages-1] = !v_q[CoreStages-1] || !stall_i;
    for (int k = CoreStages - 2; k >= 0; k--) begin
      go[k] = !v_q[k] || go[k+1];
    end
  end

  for (genvar k = 0; k < CoreStages; k++) begin : g_st
    pipe_t src;
    pipe_t nxt;
    logic  v_src;

    if (k == 0) begin : g_first
      assign src   = pipe_i;
      assign v_src = valid_i;
    end else begin : g_mid
      assign src   = st_q[k-1];
      assign v_src = v_q[k-1];
    end

    if (k < SqStages) begin : g_sq
      always_comb begin
        nxt = src;
        for (int n = 0; n < SqPerStage; n++) begin
          nxt = sq_iter(nxt);
        end
      end
    end else if (k == SqStages) begin : g_setup
      always_comb begin
        nxt = div_setup(src);
      end
    end else begin : g_div
      always_comb begin
        nxt = src;
        for (int n = 0; n < DivPerStage; n++) begin
          nxt = div_iter(nxt);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (go[k]) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (go[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign stall_o = !go[0];
  assign valid_o = v_q[CoreStages-1];
  assign pipe_o  = st_q[CoreStages-1];

endmodule

### design/rotation_matrix_to_quaternion_top.sv
// Channel   Direction  Handshake          Word
// input     in         valid_i / stall_o  col0_x_i .. col2_z_i (Q1.14 matrix columns)
// output    out        valid_o / stall_i  quat_w_o .. quat_z_o, degenerate_o
//
// One word in and one word out per cycle when nothing stalls.
// Registers in order: input register, branch select, 8 root stages
// (2 root bits each), divider setup, 8 divider stages (4 quotient bits
// each), output register. rst_ni clears only the valid bits.
// A stall at the output backs up stage by stage; empty stages keep filling,
// so the input stalls only when every stage holds a word.
module rotation_matrix_to_quaternion_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [rmq_pkg::ValW-1:0]    col0_x_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col0_y_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col0_z_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col1_x_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col1_y_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col1_z_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col2_x_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col2_y_i,
  input  logic signed [rmq_pkg::ValW-1:0]    col2_z_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [rmq_pkg::ValW-1:0]    quat_w_o,
  output logic signed [rmq_pkg::ValW-1:0]    quat_x_o,
  output logic signed [rmq_pkg::ValW-1:0]    quat_y_o,
  output logic signed [rmq_pkg::ValW-1:0]    quat_z_o,
  output logic                               degenerate_o
);
  import rmq_pkg::*;

  localparam logic signed [RadW-1:0] One    = RadW'(1) << FracBits;
  localparam int                     SatMax = 2 ** (ValW - 1) - 1;

  // ---- handshake chain, output back to input ----
  logic go_out;
  logic go1;
  logic go0;
  logic core_stall;
  logic core_valid;
  pipe_t core_pipe;

  logic  out_v_q;
  logic  v0_q;
  logic  v1_q;
  pipe_t p1_q;
  pipe_t prep_d;

  assign go_out  = !out_v_q || !stall_i;
  assign go1     = !v1_q || !core_stall;
  assign go0     = !v0_q || go1;
  assign stall_o = !go0;

  // ---- stage 0: capture the matrix, m_q[row][col] ----
  logic signed [ValW-1:0] m_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (go0) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go0) begin
      m_q[0][0] <= col0_x_i;
      m_q[1][0] <= col0_y_i;
      m_q[2][0] <= col0_z_i;
      m_q[0][1] <= col1_x_i;
      m_q[1][1] <= col1_y_i;
      m_q[2][1] <= col1_z_i;
      m_q[0][2] <= col2_x_i;
      m_q[1][2] <= col2_y_i;
      m_q[2][2] <= col2_z_i;
    end
  end

  // ---- stage 1: pick the branch, form radicand and pair values ----
  // Positive trace makes w dominant; otherwise the largest diagonal wins
  // (ties to the lower axis) and its cyclic successors give the pairs.
  logic signed [RadW-1:0] d00, d11, d22, trace, rad;
  logic signed [MagW-1:0] pv [4];

  always_comb begin
    d00   = RadW'(m_q[0][0]);
    d11   = RadW'(m_q[1][1]);
    d22   = RadW'(m_q[2][2]);
    trace = d00 + d11 + d22;
    prep_d = '0;

    if (trace > 0) begin
      prep_d.dom = SlotW;
      rad   = trace + One;
      pv[0] = '0;
      pv[1] = MagW'(m_q[2][1]) - MagW'(m_q[1][2]);
      pv[2] = MagW'(m_q[0][2]) - MagW'(m_q[2][0]);
      pv[3] = MagW'(m_q[1][0]) - MagW'(m_q[0][1]);
    end else if (d22 > d11 && d22 > d00) begin
      prep_d.dom = SlotZ;
      rad   = d22 - d00 - d11 + One;
      pv[0] = MagW'(m_q[1][0]) - MagW'(m_q[0][1]);
      pv[1] = MagW'(m_q[0][2]) + MagW'(m_q[2][0]);
      pv[2] = MagW'(m_q[1][2]) + MagW'(m_q[2][1]);
      pv[3] = '0;
    end else if (d11 > d00) begin
      prep_d.dom = SlotY;
      rad   = d11 - d22 - d00 + One;
      pv[0] = MagW'(m_q[0][2]) - MagW'(m_q[2][0]);
      pv[1] = MagW'(m_q[0][1]) + MagW'(m_q[1][0]);
      pv[2] = '0;
      pv[3] = MagW'(m_q[2][1]) + MagW'(m_q[1][2]);
    end else begin
      prep_d.dom = SlotX;
      rad   = d00 - d11 - d22 + One;
      pv[0] = MagW'(m_q[2][1]) - MagW'(m_q[1][2]);
      pv[1] = '0;
      pv[2] = MagW'(m_q[1][0]) + MagW'(m_q[0][1]);
      pv[3] = MagW'(m_q[2][0]) + MagW'(m_q[0][2]);
    end

    prep_d.degen = (rad <= 0);
    for (int l = 0; l < 4; l++) begin
      prep_d.neg[l] = pv[l][MagW-1];
      prep_d.mag[l] = pv[l][MagW-1] ? MagW'(-pv[l]) : MagW'(pv[l]);
    end
    prep_d.sq_v = SqInW'(rad[RadW-2:0]) << FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (go1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      p1_q <= prep_d;
    end
  end

  // ---- root and divider pipeline ----
  rmq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .stall_o (core_stall),
    .pipe_i  (p1_q),
    .valid_o (core_valid),
    .stall_i (!go_out),
    .pipe_o  (core_pipe)
  );

  // ---- output stage: dominant term, sign, saturate, degenerate zeroing ----
  logic [RootW:0]         dom_sum;
  logic [ValW-1:0]        dom_val;
  logic [ValW-1:0]        quat_d [4];
  logic [ValW-1:0]        quat_q [4];
  logic                   degen_q;

  always_comb begin
    dom_sum = (RootW+1)'(core_pipe.root) + (RootW+1)'(1);
    dom_val = ValW'(dom_sum >> 1);
    for (int l = 0; l < 4; l++) begin
      if (core_pipe.degen) begin
        quat_d[l] = '0;
      end else if (slot_e'(l) == core_pipe.dom) begin
        quat_d[l] = dom_val;
      end else if (core_pipe.neg[l]) begin
        if (core_pipe.dv_num[l] > NumW'(SatMax)) begin
          quat_d[l] = {1'b1, {(ValW-1){1'b0}}};
        end else begin
          quat_d[l] = -ValW'(core_pipe.dv_num[l]);
        end
      end else begin
        if (core_pipe.dv_num[l] > NumW'(SatMax)) begin
          quat_d[l] = {1'b0, {(ValW-1){1'b1}}};
        end else begin
          quat_d[l] = ValW'(core_pipe.dv_num[l]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (go_out) begin
      out_v_q <= core_valid;
    end
  end

  // Hold the word while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (go_out) begin
      quat_q  <= quat_d;
      degen_q <= core_pipe.degen;
    end
  end

  assign valid_o      = out_v_q;
  assign quat_w_o     = quat_q[0];
  assign quat_x_o     = quat_q[1];
  assign quat_y_o     = quat_q[2];
  assign quat_z_o     = quat_q[3];
  assign degenerate_o = degen_q;

endmodule

### design/rmq_checker.sv
`include "rotation_matrix_to_quaternion_top_assert.svh"

module rmq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            stall_o,
  input logic                            valid_o,
  input logic                            stall_i,
  input logic signed [rmq_pkg::ValW-1:0] quat_w_o,
  input logic signed [rmq_pkg::ValW-1:0] quat_x_o,
  input logic signed [rmq_pkg::ValW-1:0] quat_y_o,
  input logic signed [rmq_pkg::ValW-1:0] quat_z_o,
  input logic                            degenerate_o
);

  `RMQ_ASSERT(a_degen_zero, valid_o && degenerate_o,
              quat_w_o == 0 && quat_x_o == 0 && quat_y_o == 0 && quat_z_o == 0,
              "degenerate word carries nonzero quaternion")

  `RMQ_ASSERT(a_dom_positive, valid_o && !degenerate_o,
              quat_w_o > 0 || quat_x_o > 0 || quat_y_o > 0 || quat_z_o > 0,
              "no positive dominant component")

  `RMQ_ASSERT(a_full_only, stall_o, valid_o && stall_i, "input stalled while output not blocked")

  `RMQ_ASSERT_NEXT(a_out_hold, valid_o && stall_i,
                   valid_o && $stable(quat_w_o) && $stable(quat_x_o) &&
                   $stable(quat_y_o) && $stable(quat_z_o) && $stable(degenerate_o),
                   "stalled output word changed")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
